@@ rtl/ffd_pkg.sv @@
// ffd_pkg: shared constants, types and helpers of the fixed frame deframer
// no dependencies; compiled first

package ffd_pkg;

  localparam int WIN_LEN = 42;
  localparam int IDX_W = $clog2(WIN_LEN);
  localparam int CNT_W = $clog2(WIN_LEN + 1);
  localparam int CFG_IDX_W = 2;

  localparam logic [7:0] HEADER_FIRST_RST  = 8'hAA;
  localparam logic [7:0] HEADER_SECOND_RST = 8'h55;
  localparam logic [7:0] TAIL_VALUE_RST    = 8'h00;

  localparam logic [CFG_IDX_W-1:0] REG_HEADER_FIRST  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_SECOND = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_TAIL_VALUE    = CFG_IDX_W'(2);

  localparam logic [CNT_W-1:0] CNT_FULL_M1 = CNT_W'(WIN_LEN - 1);

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_t;

  typedef struct packed {
    logic accept;    // write received byte into window
    logic drop;      // header or tail mismatch: slide window by one
    logic consume;   // headers and tail matched: window emptied
    logic fetch_ld;  // capture refreshed second-oldest byte
    logic emit_rd;   // read next frame byte
    logic emit_ld;   // load frame byte into output register
  } cmd_t;

  typedef struct packed {
    logic fill_hit;  // next byte fills the window
    logic hdr_ok;    // headers and tail match with the incoming byte
    logic sum_ok;    // checksum matches with the incoming byte
    logic out_free;  // output register can take a byte next cycle
    logic emit_last; // current emit byte is the final one
  } status_t;

  // ring index add, a < WIN_LEN and b < WIN_LEN
  function automatic idx_t wrap_add(idx_t a, cnt_t b);
    logic [CNT_W:0] s;
    s = {{(CNT_W + 1 - IDX_W){1'b0}}, a} + {1'b0, b};
    if (s >= (CNT_W + 1)'(WIN_LEN)) begin
      s = s - (CNT_W + 1)'(WIN_LEN);
    end
    return s[IDX_W-1:0];
  endfunction

endpackage

@@ rtl/ffd_if.sv @@
// ffd_if: channel interfaces for received bytes, frame bytes and register writes
// depends on ffd_pkg for the register index width

interface ffd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface ffd_frame_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_last;
  modport source (output valid, output frame_byte, output frame_last, input ready);
  modport sink (input valid, input frame_byte, input frame_last, output ready);
endinterface

interface ffd_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [ffd_pkg::CFG_IDX_W-1:0]  index;
  logic [7:0]                     data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/ffd_ctrl.sv @@
// ffd_ctrl: controller state machine of the deframer
// depends on ffd_pkg for state, command and status types

module ffd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  ffd_pkg::status_t  st,
  output ffd_pkg::cmd_t     cmd
);
  import ffd_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (st.fill_hit) begin
            if (!st.hdr_ok) begin
              cmd.drop   = 1'b1;
              state_next = ST_FETCH;
            end else begin
              cmd.consume = 1'b1;
              if (st.sum_ok) begin
                state_next = ST_EMIT_RD;
              end
            end
          end
        end
      end
      ST_FETCH: begin
        cmd.fetch_ld = 1'b1;
        state_next   = ST_IDLE;
      end
      ST_EMIT_RD: begin
        if (st.out_free) begin
          cmd.emit_rd = 1'b1;
          state_next  = ST_EMIT_LD;
        end
      end
      ST_EMIT_LD: begin
        cmd.emit_ld = 1'b1;
        state_next  = st.emit_last ? ST_IDLE : ST_EMIT_RD;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/ffd_dpath.sv @@
// ffd_dpath: window ring memory, header tracking, running xor, config and output register
// depends on ffd_pkg for widths, command and status types

module ffd_dpath (
  input  logic                           clk,
  input  logic                           rst,
  input  ffd_pkg::cmd_t                  cmd,
  output ffd_pkg::status_t               st,
  input  logic [7:0]                     rx_byte,
  input  logic                           cfg_we,
  input  logic [ffd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [7:0]                     cfg_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [7:0]                     frame_byte,
  output logic                           frame_last
);
  import ffd_pkg::*;

  logic [7:0] mem [WIN_LEN];
  logic [7:0] rdata;
  idx_t       raddr;
  idx_t       waddr;

  logic [7:0] header_first, header_second, tail_value;
  idx_t       head;
  cnt_t       fill;
  cnt_t       emit_k;
  logic [7:0] total;   // xor of all bytes held in the window
  logic [7:0] first0, first1;

  assign waddr = wrap_add(head, fill);
  // on a slide, fetch the byte that becomes second oldest
  assign raddr = cmd.drop ? wrap_add(head, CNT_W'(2)) : wrap_add(head, emit_k);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mem[waddr] <= rx_byte;
    end
    rdata <= mem[raddr];
  end

  always_comb begin
    st.fill_hit  = (fill == CNT_FULL_M1);
    st.hdr_ok    = (first0 == header_first) && (first1 == header_second) &&
                   (rx_byte == tail_value);
    // payload xor equals the check byte iff the rest of the frame xors to zero
    st.sum_ok    = ((total ^ rx_byte ^ header_first ^ header_second ^ tail_value) == 8'h00);
    st.out_free  = !out_valid || out_ready;
    st.emit_last = (emit_k == CNT_FULL_M1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_first  <= HEADER_FIRST_RST;
      header_second <= HEADER_SECOND_RST;
      tail_value    <= TAIL_VALUE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HEADER_FIRST:  header_first  <= cfg_data;
        REG_HEADER_SECOND: header_second <= cfg_data;
        REG_TAIL_VALUE:    tail_value    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      fill  <= '0;
      total <= '0;
    end else if (cmd.drop) begin
      head  <= wrap_add(head, CNT_W'(1));
      fill  <= CNT_FULL_M1;
      total <= total ^ rx_byte ^ first0;
    end else if (cmd.consume) begin
      fill  <= '0;
      total <= '0;
    end else if (cmd.accept) begin
      fill  <= fill + CNT_W'(1);
      total <= total ^ rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.drop) begin
      first0 <= first1;
    end else if (cmd.accept && (fill == '0)) begin
      first0 <= rx_byte;
    end
    if (cmd.fetch_ld) begin
      first1 <= rdata;
    end else if (cmd.accept && (fill == CNT_W'(1))) begin
      first1 <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      emit_k <= '0;
    end else if (cmd.consume) begin
      emit_k <= '0;
    end else if (cmd.emit_ld) begin
      emit_k <= emit_k + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_ld) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_ld) begin
      frame_byte <= rdata;
      frame_last <= st.emit_last;
    end
  end

endmodule

@@ rtl/fixed_frame_deframer_xor_unit.sv @@
// fixed_frame_deframer_xor_unit: top level, joins controller and datapath
// depends on ffd_pkg, ffd_if, ffd_ctrl, ffd_dpath
//
//   channel  dir  payload                  transaction when
//   rx       in   rx_byte[7:0]             rx.valid && rx.ready
//   frame    out  frame_byte[7:0], last    frame.valid && frame.ready
//   cfg      in   index[1:0], data[7:0]    cfg.valid && cfg.ready (always ready)
//
// a received byte is taken in ST_IDLE; a header or tail mismatch slides the window
// and ST_FETCH takes the refreshed second byte from the window memory read port
// a valid frame is sent as 42 bytes, each read then loaded via the one read port;
// no rx byte is taken until the last frame byte is in the output register
// synchronous reset clears control state and restores the register defaults
// the output register holds a byte under stall while the next rx byte is taken

module fixed_frame_deframer_xor_unit (
  input  logic  clk,
  input  logic  rst,
  ffd_rx_if.sink      rx,
  ffd_frame_if.source frame,
  ffd_cfg_if.sink     cfg
);
  import ffd_pkg::*;

  cmd_t    cmd;
  status_t st;
  logic    out_valid;

  assign cfg.ready   = 1'b1;
  assign frame.valid = out_valid;

  ffd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (rx.valid),
    .in_ready (rx.ready),
    .st       (st),
    .cmd      (cmd)
  );

  ffd_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .st         (st),
    .rx_byte    (rx.rx_byte),
    .cfg_we     (cfg.valid),
    .cfg_index  (cfg.index),
    .cfg_data   (cfg.data),
    .out_valid  (out_valid),
    .out_ready  (frame.ready),
    .frame_byte (frame.frame_byte),
    .frame_last (frame.frame_last)
  );

  // mid-frame no rx byte may be taken
  a_no_rx_mid_frame: assert property (@(posedge clk) disable iff (rst)
    frame.valid && !frame.frame_last |-> !rx.ready)
    else $error("rx byte taken while a frame is being sent");

  // a slide is followed by the refresh fetch and no new byte
  a_drop_fetch: assert property (@(posedge clk) disable iff (rst)
    cmd.drop |=> cmd.fetch_ld && !rx.ready)
    else $error("window slide not followed by fetch");

  // each output load follows a memory read
  a_load_after_read: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_ld |-> $past(cmd.emit_rd))
    else $error("frame byte loaded without a read");

endmodule
